>>> hdl/fdqd_pkg.sv
// Shared types, constants and helper functions of the queue dispatcher.
`default_nettype none

package fdqd_pkg;

  localparam int NUM_UE_DEF      = 4;
  localparam int QUEUE_DEPTH_DEF = 2048;
  localparam int MAX_BURST_DEF   = 8;

  localparam int DESC_W = 27;

  localparam logic [15:0] REG_REQ_ID    = 16'h00FF;
  localparam logic [10:0] REG_FRAME_LEN = 11'd6;

  localparam logic [47:0] AP_MAC_0_RST  = 48'd43838865413;
  localparam logic [47:0] AP_MAC_1_RST  = 48'd43838865416;
  localparam logic [47:0] AP_MAC_2_RST  = 48'd43838865409;
  localparam logic [47:0] AP_MAC_3_RST  = 48'd43838865412;
  localparam logic [15:0] POWER_THR_RST = 16'd160;
  localparam logic [3:0]  MAX_LED_RST   = 4'd12;

  typedef enum logic [2:0] {
    CFG_AP_MAC_0,
    CFG_AP_MAC_1,
    CFG_AP_MAC_2,
    CFG_AP_MAC_3,
    CFG_POWER_THR,
    CFG_MAX_LED
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_QUEUED,
    KIND_FULL,
    KIND_REJECTED,
    KIND_REG_FRAME,
    KIND_DATA_FRAME,
    KIND_EMPTY,
    KIND_NO_SLOT
  } kind_e;

  typedef struct packed {
    logic [3:0][47:0] ap_mac;
    logic [15:0]      power_thr;
    logic [3:0]       max_led;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  queue_index;
    logic [10:0] packet_len;
    logic [15:0] packet_tag;
    logic [15:0] fb_ue_id;
    logic [15:0] fb_led_id;
    logic [15:0] fb_power;
    logic [47:0] fb_ue_mac;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [47:0] dest_mac;
    logic [1:0]  timeslot;
    logic [10:0] payload_len;
    logic [3:0]  led_id;
    logic [2:0]  ue_id;
    logic [47:0] ue_mac;
    logic [15:0] out_tag;
    logic        last;
  } res_t;

  function automatic logic [1:0] ap_index(input logic [3:0] led);
    logic [1:0] idx;
    if (led >= 4'd10) begin
      idx = 2'd3;
    end else if (led >= 4'd7) begin
      idx = 2'd2;
    end else if (led >= 4'd4) begin
      idx = 2'd1;
    end else begin
      idx = 2'd0;
    end
    return idx;
  endfunction

  // Slot for a zero-based terminal number: (x mod 3) + 1.
  function automatic logic [1:0] slot_of(input logic [3:0] x);
    logic [3:0] r;
    r = x;
    if (r >= 4'd12) r = r - 4'd12;
    if (r >= 4'd6) r = r - 4'd6;
    if (r >= 4'd3) r = r - 4'd3;
    return r[1:0] + 2'd1;
  endfunction

endpackage

`default_nettype wire

>>> hdl/fdqd_desc_ram.sv
// Descriptor memory: one write port, one registered read port.
`default_nettype none

module fdqd_desc_ram #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13,
  parameter int DATA_W = 27
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/fdqd_seq.sv
// Sequencer: decode, registration scan, ring bookkeeping and burst drain.
`default_nettype none

module fdqd_seq #(
  parameter int NUM_UE      = 4,
  parameter int QUEUE_DEPTH = 2048,
  parameter int MAX_BURST   = 8,
  parameter int ADDR_W      = 13
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_fire_i,
  input  wire fdqd_pkg::item_t           item_i,
  output logic                           idle_o,
  input  wire fdqd_pkg::cfg_t            cfg_i,
  output logic                           res_valid_o,
  input  wire logic                      res_ready_i,
  output fdqd_pkg::res_t                 res_o,
  output logic                           mem_we_o,
  output logic [ADDR_W-1:0]              mem_waddr_o,
  output logic [fdqd_pkg::DESC_W-1:0]    mem_wdata_o,
  output logic [ADDR_W-1:0]              mem_raddr_o,
  input  wire logic [fdqd_pkg::DESC_W-1:0] mem_rdata_i
);

  import fdqd_pkg::*;

  localparam int QW  = (NUM_UE > 1) ? $clog2(NUM_UE) : 1;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int BW  = $clog2(MAX_BURST + 1);
  localparam int IDW = $clog2(NUM_UE + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RD,
    S_DATA,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ENQ,
    OP_REG
  } op_e;

  state_e          state_q;
  op_e             op_q;
  item_t           item_q;
  logic [QW-1:0]   aq_q;
  logic [QW-1:0]   scan_q;
  logic [IDW-1:0]  id_q;
  logic [BW-1:0]   rem_q;
  res_t            res_q;
  logic [PW-1:0]   head_q [NUM_UE];
  logic [PW-1:0]   tail_q [NUM_UE];
  logic [CW-1:0]   cnt_q [NUM_UE];
  logic [47:0]     reg_mac_q [NUM_UE];

  logic [QW-1:0]   aq_d;
  logic [3:0]      led4;
  logic [47:0]     dmac;
  logic            fb_bad;
  logic            pkt_q_ok;
  logic            ue_ok;
  logic            is_reg;
  logic [CW-1:0]   cur_cnt;
  logic [PW-1:0]   cur_head;
  logic [PW-1:0]   cur_tail;
  logic [PW-1:0]   head_inc;
  logic [PW-1:0]   tail_inc;
  logic [BW-1:0]   burst_n;
  logic [7:0]      scan_byte;
  logic [IDW-1:0]  scan_id;
  logic [IDW-1:0]  id_n;
  logic            res_fire;
  res_t            dec_res;
  op_e             dec_op;
  state_e          dec_next;
  res_t            reg_res;
  res_t            data_res;

  function automatic logic [ADDR_W-1:0] desc_addr(input logic [QW-1:0] q,
                                                  input logic [PW-1:0] ptr);
    return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
  endfunction

  always_comb begin
    if (item_i.cmd) begin
      aq_d = QW'(item_i.fb_ue_id - 16'd1);
    end else begin
      aq_d = QW'(item_i.queue_index);
    end
  end

  assign led4     = item_q.fb_led_id[3:0];
  assign dmac     = cfg_i.ap_mac[ap_index(led4)];
  assign fb_bad   = (item_q.fb_led_id == 16'd0) ||
                    (item_q.fb_led_id > 16'(cfg_i.max_led)) ||
                    (item_q.fb_power < cfg_i.power_thr);
  assign pkt_q_ok = int'(item_q.queue_index) < NUM_UE;
  assign ue_ok    = (item_q.fb_ue_id != 16'd0) && (item_q.fb_ue_id <= 16'(NUM_UE));
  assign is_reg   = item_q.fb_ue_id == REG_REQ_ID;

  assign cur_cnt  = cnt_q[aq_q];
  assign cur_head = head_q[aq_q];
  assign cur_tail = tail_q[aq_q];
  assign head_inc = (cur_head == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + PW'(1);
  assign tail_inc = (cur_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_tail + PW'(1);
  assign burst_n  = (int'(cur_cnt) > MAX_BURST) ? BW'(MAX_BURST) : BW'(cur_cnt);

  // Registration scan: a low-byte match takes the slot, a free slot only if none yet.
  assign scan_byte = reg_mac_q[scan_q][7:0];
  assign scan_id   = IDW'(scan_q) + IDW'(1);
  always_comb begin
    id_n = id_q;
    if (scan_byte == item_q.fb_ue_mac[7:0]) id_n = scan_id;
    if ((scan_byte == 8'd0) && (id_n == '0)) id_n = scan_id;
  end

  always_comb begin
    reg_res      = '0;
    reg_res.last = 1'b1;
    if (id_n == '0) begin
      reg_res.kind = KIND_NO_SLOT;
    end else begin
      reg_res.kind        = KIND_REG_FRAME;
      reg_res.dest_mac    = dmac;
      reg_res.timeslot    = slot_of(4'(id_n - IDW'(1)));
      reg_res.payload_len = REG_FRAME_LEN;
      reg_res.led_id      = led4;
      reg_res.ue_id       = 3'(id_n);
      reg_res.ue_mac      = item_q.fb_ue_mac;
    end
  end

  always_comb begin
    dec_res      = '0;
    dec_res.last = 1'b1;
    dec_op       = OP_NONE;
    dec_next     = S_EMIT;
    if (!item_q.cmd) begin
      if (!pkt_q_ok) begin
        dec_res.kind = KIND_REJECTED;
      end else if (cur_cnt == CW'(QUEUE_DEPTH)) begin
        dec_res.kind = KIND_FULL;
      end else begin
        dec_res.kind = KIND_QUEUED;
        dec_op       = OP_ENQ;
      end
    end else if (fb_bad) begin
      dec_res.kind = KIND_REJECTED;
    end else if (is_reg) begin
      dec_next = S_SCAN;
    end else if (!ue_ok) begin
      dec_res.kind = KIND_REJECTED;
    end else if (cur_cnt == '0) begin
      dec_res.kind = KIND_EMPTY;
    end else begin
      dec_next = S_RD;
    end
  end

  always_comb begin
    data_res             = '0;
    data_res.kind        = KIND_DATA_FRAME;
    data_res.dest_mac    = dmac;
    data_res.timeslot    = slot_of(4'(item_q.fb_ue_id - 16'd1));
    data_res.payload_len = mem_rdata_i[26:16];
    data_res.led_id      = led4;
    data_res.ue_id       = 3'(item_q.fb_ue_id);
    data_res.out_tag     = mem_rdata_i[15:0];
    data_res.last        = rem_q == BW'(1);
  end

  assign idle_o      = state_q == S_IDLE;
  assign res_valid_o = (state_q == S_EMIT) || (state_q == S_DATA);
  assign res_o       = (state_q == S_DATA) ? data_res : res_q;
  assign res_fire    = res_valid_o && res_ready_i;

  assign mem_we_o    = res_fire && (state_q == S_EMIT) && (op_q == OP_ENQ);
  assign mem_waddr_o = desc_addr(aq_q, cur_tail);
  assign mem_wdata_o = {item_q.packet_len, item_q.packet_tag};
  assign mem_raddr_o = desc_addr(aq_q,
                                 ((state_q == S_DATA) && res_fire) ? head_inc : cur_head);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NONE;
      item_q  <= '0;
      aq_q    <= '0;
      scan_q  <= '0;
      id_q    <= '0;
      rem_q   <= '0;
      res_q   <= '0;
      for (int i = 0; i < NUM_UE; i++) begin
        head_q[i]    <= '0;
        tail_q[i]    <= '0;
        cnt_q[i]     <= '0;
        reg_mac_q[i] <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire_i) begin
            item_q  <= item_i;
            aq_q    <= aq_d;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_q   <= dec_res;
          op_q    <= dec_op;
          scan_q  <= '0;
          id_q    <= '0;
          rem_q   <= burst_n;
          state_q <= dec_next;
        end
        S_SCAN: begin
          id_q   <= id_n;
          scan_q <= scan_q + QW'(1);
          if (scan_q == QW'(NUM_UE - 1)) begin
            res_q   <= reg_res;
            op_q    <= (id_n != '0) ? OP_REG : OP_NONE;
            state_q <= S_EMIT;
          end
        end
        S_RD: begin
          state_q <= S_DATA;
        end
        S_DATA: begin
          if (res_fire) begin
            head_q[aq_q] <= head_inc;
            cnt_q[aq_q]  <= cur_cnt - CW'(1);
            rem_q        <= rem_q - BW'(1);
            if (rem_q == BW'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (res_fire) begin
            case (op_q)
              OP_ENQ: begin
                tail_q[aq_q] <= tail_inc;
                cnt_q[aq_q]  <= cur_cnt + CW'(1);
              end
              OP_REG: begin
                reg_mac_q[QW'(id_q - IDW'(1))] <= item_q.fb_ue_mac;
              end
              default: begin
              end
            endcase
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA) |-> ((cur_cnt != '0) && (rem_q != '0)))
    else $error("drain on empty ring or exhausted burst");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && res_o.last) |=> (state_q == S_IDLE))
    else $error("sequencer busy after final result");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DATA) && res_fire && !res_o.last) |=> (state_q == S_DATA))
    else $error("burst cut short");

  a_enq_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (cur_cnt < CW'(QUEUE_DEPTH)))
    else $error("write into full ring");

  a_reg_has_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && (op_q == OP_REG)) |-> ((id_q != '0) && (res_q.ue_id != 3'd0 ||
      IDW > 3)))
    else $error("registration without slot");

endmodule

`default_nettype wire

>>> hdl/feedback_driven_queue_dispatcher.sv
// Packet items and rejected feedback: the result is decoded into the result register, then the output register.
// Registration feedback: a scan of the table, one slot compared per cycle, before the result is emitted.
// Data feedback: after a descriptor read, one frame per cycle up to MAX_BURST while the output
// is not stalled, paced by the single descriptor memory read port.
// The input stalls until the final result of an item enters the output register.
// Reset clears rings, counts, registration table and registers; descriptors are not cleared.
`default_nettype none

module feedback_driven_queue_dispatcher #(
  parameter int NUM_UE      = fdqd_pkg::NUM_UE_DEF,
  parameter int QUEUE_DEPTH = fdqd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_BURST   = fdqd_pkg::MAX_BURST_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [1:0]  queue_index_i,
  input  wire logic [10:0] packet_len_i,
  input  wire logic [15:0] packet_tag_i,
  input  wire logic [15:0] fb_ue_id_i,
  input  wire logic [15:0] fb_led_id_i,
  input  wire logic [15:0] fb_power_i,
  input  wire logic [47:0] fb_ue_mac_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [47:0]      dest_mac_o,
  output logic [1:0]       timeslot_o,
  output logic [10:0]      payload_len_o,
  output logic [3:0]       led_id_o,
  output logic [2:0]       ue_id_o,
  output logic [47:0]      ue_mac_o,
  output logic [15:0]      out_tag_o,
  output logic             last_o
);

  import fdqd_pkg::*;

  localparam int MEM_DEPTH = NUM_UE * QUEUE_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  cfg_t              cfg_q;
  logic              out_valid_q;
  res_t              out_q;
  item_t             item;
  logic              seq_idle;
  logic              in_fire;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DESC_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DESC_W-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ap_mac[0] <= AP_MAC_0_RST;
      cfg_q.ap_mac[1] <= AP_MAC_1_RST;
      cfg_q.ap_mac[2] <= AP_MAC_2_RST;
      cfg_q.ap_mac[3] <= AP_MAC_3_RST;
      cfg_q.power_thr <= POWER_THR_RST;
      cfg_q.max_led   <= MAX_LED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_AP_MAC_0:  cfg_q.ap_mac[0] <= cfg_wdata_i;
        CFG_AP_MAC_1:  cfg_q.ap_mac[1] <= cfg_wdata_i;
        CFG_AP_MAC_2:  cfg_q.ap_mac[2] <= cfg_wdata_i;
        CFG_AP_MAC_3:  cfg_q.ap_mac[3] <= cfg_wdata_i;
        CFG_POWER_THR: cfg_q.power_thr <= cfg_wdata_i[15:0];
        CFG_MAX_LED:   cfg_q.max_led <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  assign item.cmd         = cmd_i;
  assign item.queue_index = queue_index_i;
  assign item.packet_len  = packet_len_i;
  assign item.packet_tag  = packet_tag_i;
  assign item.fb_ue_id    = fb_ue_id_i;
  assign item.fb_led_id   = fb_led_id_i;
  assign item.fb_power    = fb_power_i;
  assign item.fb_ue_mac   = fb_ue_mac_i;

  assign in_stall_o = !seq_idle;
  assign in_fire    = in_valid_i && seq_idle;
  assign res_ready  = !out_valid_q || !out_stall_i;

  fdqd_seq #(
    .NUM_UE      (NUM_UE),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_BURST   (MAX_BURST),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .item_i      (item),
    .idle_o      (seq_idle),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fdqd_desc_ram #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DESC_W)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign dest_mac_o    = out_q.dest_mac;
  assign timeslot_o    = out_q.timeslot;
  assign payload_len_o = out_q.payload_len;
  assign led_id_o      = out_q.led_id;
  assign ue_id_o       = out_q.ue_id;
  assign ue_mac_o      = out_q.ue_mac;
  assign out_tag_o     = out_q.out_tag;
  assign last_o        = out_q.last;

endmodule

`default_nettype wire

>>> tb/sv/tb_feedback_driven_queue_dispatcher.sv
// Self-checking testbench for the feedback-driven queue dispatcher with its own shadow predictor.
`timescale 1ns / 100ps

module tb_feedback_driven_queue_dispatcher;
  import fdqd_pkg::*;

  localparam int NUE         = NUM_UE_DEF;
  localparam int QD          = QUEUE_DEPTH_DEF;
  localparam int BURST       = MAX_BURST_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 12;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [47:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        cmd_i         = 1'b0;
  logic [1:0]  queue_index_i = '0;
  logic [10:0] packet_len_i  = '0;
  logic [15:0] packet_tag_i  = '0;
  logic [15:0] fb_ue_id_i    = '0;
  logic [15:0] fb_led_id_i   = '0;
  logic [15:0] fb_power_i    = '0;
  logic [47:0] fb_ue_mac_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [2:0]  kind_o;
  logic [47:0] dest_mac_o;
  logic [1:0]  timeslot_o;
  logic [10:0] payload_len_o;
  logic [3:0]  led_id_o;
  logic [2:0]  ue_id_o;
  logic [47:0] ue_mac_o;
  logic [15:0] out_tag_o;
  logic        last_o;

  feedback_driven_queue_dispatcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .queue_index_i (queue_index_i),
    .packet_len_i  (packet_len_i),
    .packet_tag_i  (packet_tag_i),
    .fb_ue_id_i    (fb_ue_id_i),
    .fb_led_id_i   (fb_led_id_i),
    .fb_power_i    (fb_power_i),
    .fb_ue_mac_i   (fb_ue_mac_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .dest_mac_o    (dest_mac_o),
    .timeslot_o    (timeslot_o),
    .payload_len_o (payload_len_o),
    .led_id_o      (led_id_o),
    .ue_id_o       (ue_id_o),
    .ue_mac_o      (ue_mac_o),
    .out_tag_o     (out_tag_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Shadow state of the dispatcher
  logic [47:0] ap_mac_sh [4];
  logic [15:0] power_thr_sh;
  logic [3:0]  max_led_sh;
  logic [10:0] ring_len [NUE][QD];
  logic [15:0] ring_tag [NUE][QD];
  int          ring_head [NUE];
  int          ring_tail [NUE];
  int          ring_count [NUE];
  logic [47:0] term_mac [NUE];

  res_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req_cnt  = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int fails         = 0;
  int results_seen  = 0;
  int items_sent    = 0;
  int cfg_writes    = 0;
  int cycles        = 0;

  initial begin
    ap_mac_sh[0] = AP_MAC_0_RST;
    ap_mac_sh[1] = AP_MAC_1_RST;
    ap_mac_sh[2] = AP_MAC_2_RST;
    ap_mac_sh[3] = AP_MAC_3_RST;
    power_thr_sh = POWER_THR_RST;
    max_led_sh   = MAX_LED_RST;
    for (int i = 0; i < NUE; i++) begin
      ring_head[i]  = 0;
      ring_tail[i]  = 0;
      ring_count[i] = 0;
      term_mac[i]   = '0;
    end
  end

  function automatic res_t status_result(kind_e k);
    res_t r;
    r      = '0;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void predict_dispatch(item_t it);
    res_t        r;
    int          q;
    int          id;
    int          n;
    int          ue;
    int          ai;
    logic [47:0] dmac;
    if (!it.cmd) begin
      q = it.queue_index;
      if (q >= NUE) begin
        pending_results.push_back(status_result(KIND_REJECTED));
      end else if (ring_count[q] >= QD) begin
        pending_results.push_back(status_result(KIND_FULL));
      end else begin
        ring_len[q][ring_tail[q]] = it.packet_len;
        ring_tag[q][ring_tail[q]] = it.packet_tag;
        ring_tail[q] = (ring_tail[q] + 1) % QD;
        ring_count[q]++;
        pending_results.push_back(status_result(KIND_QUEUED));
      end
      return;
    end
    if (it.fb_led_id == 16'd0 || it.fb_led_id > {12'd0, max_led_sh} ||
        it.fb_power < power_thr_sh) begin
      pending_results.push_back(status_result(KIND_REJECTED));
      return;
    end
    ai = (int'(it.fb_led_id) - 1) / 3;
    if (ai > 3) ai = 3;
    dmac = ap_mac_sh[ai];
    if (it.fb_ue_id == REG_REQ_ID) begin
      id = 0;
      for (int i = 0; i < NUE; i++) begin
        if (term_mac[i][7:0] == it.fb_ue_mac[7:0]) id = i + 1;
        if (term_mac[i][7:0] == 8'd0 && id == 0) id = i + 1;
      end
      if (id == 0) begin
        pending_results.push_back(status_result(KIND_NO_SLOT));
        return;
      end
      r             = status_result(KIND_REG_FRAME);
      r.dest_mac    = dmac;
      r.timeslot    = 2'(((id - 1) % 3) + 1);
      r.payload_len = REG_FRAME_LEN;
      r.led_id      = it.fb_led_id[3:0];
      r.ue_id       = 3'(id);
      r.ue_mac      = it.fb_ue_mac;
      pending_results.push_back(r);
      term_mac[id - 1] = it.fb_ue_mac;
      return;
    end
    ue = it.fb_ue_id;
    if (ue == 0 || ue > NUE) begin
      pending_results.push_back(status_result(KIND_REJECTED));
      return;
    end
    q = ue - 1;
    n = ring_count[q];
    if (n == 0) begin
      pending_results.push_back(status_result(KIND_EMPTY));
      return;
    end
    if (n > BURST) n = BURST;
    for (int k = 0; k < n; k++) begin
      r             = status_result(KIND_DATA_FRAME);
      r.dest_mac    = dmac;
      r.timeslot    = 2'((q % 3) + 1);
      r.payload_len = ring_len[q][ring_head[q]];
      r.led_id      = it.fb_led_id[3:0];
      r.ue_id       = 3'(ue);
      r.out_tag     = ring_tag[q][ring_head[q]];
      r.last        = (k + 1 == n);
      pending_results.push_back(r);
      ring_head[q] = (ring_head[q] + 1) % QD;
      ring_count[q]--;
    end
  endfunction

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no pending transaction: kind %0d", kind_o);
        fails++;
      end else begin
        e = pending_results.pop_front();
        check_field("kind", e.kind, kind_o);
        check_field("dest_mac", e.dest_mac, dest_mac_o);
        check_field("timeslot", e.timeslot, timeslot_o);
        check_field("payload_len", e.payload_len, payload_len_o);
        check_field("led_id", e.led_id, led_id_o);
        check_field("ue_id", e.ue_id, ue_id_o);
        check_field("ue_mac", e.ue_mac, ue_mac_o);
        check_field("out_tag", e.out_tag, out_tag_o);
        check_field("last", e.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("feedback_driven_queue_dispatcher verification failed");
      $finish;
    end
  end

  function automatic item_t pkt(int q, logic [10:0] len, logic [15:0] tag);
    item_t it;
    it             = '0;
    it.queue_index = 2'(q);
    it.packet_len  = len;
    it.packet_tag  = tag;
    return it;
  endfunction

  function automatic item_t fb(logic [15:0] ue, logic [15:0] led, logic [15:0] pwr,
                               logic [47:0] mac);
    item_t it;
    it           = '0;
    it.cmd       = 1'b1;
    it.fb_ue_id  = ue;
    it.fb_led_id = led;
    it.fb_power  = pwr;
    it.fb_ue_mac = mac;
    return it;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= it.cmd;
    queue_index_i <= it.queue_index;
    packet_len_i  <= it.packet_len;
    packet_tag_i  <= it.packet_tag;
    fb_ue_id_i    <= it.fb_ue_id;
    fb_led_id_i   <= it.fb_led_id;
    fb_power_i    <= it.fb_power;
    fb_ue_mac_i   <= it.fb_ue_mac;
    do @(posedge clk_i); while (in_stall_o);
    predict_dispatch(it);
    items_sent++;
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [47:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      CFG_AP_MAC_0:  ap_mac_sh[0] = v;
      CFG_AP_MAC_1:  ap_mac_sh[1] = v;
      CFG_AP_MAC_2:  ap_mac_sh[2] = v;
      CFG_AP_MAC_3:  ap_mac_sh[3] = v;
      CFG_POWER_THR: power_thr_sh = v[15:0];
      CFG_MAX_LED:   max_led_sh = v[3:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic item_t random_item();
    item_t       it;
    int          sel;
    logic [47:0] mac;
    logic [7:0]  low_bytes [6];
    low_bytes = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h00};
    sel = $urandom_range(99);
    mac = rand48();
    if (sel < 45) begin
      it = pkt($urandom_range(3), ($urandom_range(3) == 0) ? 11'($urandom_range(2047)) :
               11'($urandom_range(1500)), 16'($urandom()));
    end else if (sel < 60) begin
      mac[7:0] = low_bytes[$urandom_range(5)];
      it = fb(REG_REQ_ID, 16'($urandom_range(max_led_sh, 1)),
              16'($urandom_range(65535, power_thr_sh)), mac);
    end else if (sel < 88) begin
      it = fb(16'($urandom_range(NUE, 1)), 16'($urandom_range(max_led_sh, 1)),
              16'($urandom_range(65535, power_thr_sh)), mac);
    end else begin
      it             = '0;
      it.cmd         = 1'b1;
      it.fb_ue_id    = 16'($urandom());
      it.fb_led_id   = ($urandom_range(1) == 0) ? 16'($urandom()) : 16'($urandom_range(15));
      it.fb_power    = 16'($urandom());
      it.fb_ue_mac   = mac;
      it.queue_index = 2'($urandom());
      it.packet_len  = 11'($urandom());
      it.packet_tag  = 16'($urandom());
    end
    return it;
  endfunction

  task automatic random_config();
    cfg_write(CFG_AP_MAC_0, rand48());
    cfg_write(CFG_AP_MAC_1, rand48());
    cfg_write(CFG_AP_MAC_2, rand48());
    cfg_write(CFG_AP_MAC_3, rand48());
    cfg_write(CFG_POWER_THR, 48'($urandom_range(400)));
    cfg_write(CFG_MAX_LED, 48'($urandom_range(12, 1)));
  endtask

  task automatic test_packet_extremes();
    send_item(pkt(0, 11'd0, 16'h0000));
    send_item(pkt(1, 11'd1500, 16'hFFFF));
    send_item(pkt(2, 11'h7FF, 16'h5555));
    send_item(pkt(3, 11'h2AA, 16'hAAAA));
    wait_quiet();
  endtask

  task automatic test_burst_drain();
    for (int i = 0; i < 10; i++) send_item(pkt(0, 11'($urandom_range(1500)), 16'($urandom())));
    send_item(fb(16'd1, 16'd1, 16'hFFFF, 48'd0));
    send_item(fb(16'd1, 16'd12, 16'd160, 48'd0));
    send_item(fb(16'd1, 16'd6, 16'd200, 48'd0));
    send_item(fb(16'd4, 16'd9, 16'd500, 48'd0));
    wait_quiet();
  endtask

  task automatic test_feedback_rejects();
    send_item(fb(16'd2, 16'd0, 16'hFFFF, 48'd0));
    send_item(fb(16'd2, 16'd13, 16'hFFFF, 48'd0));
    send_item(fb(16'd2, 16'd4, 16'd159, 48'd0));
    send_item(fb(16'd0, 16'd4, 16'd400, 48'd0));
    send_item(fb(16'd5, 16'd4, 16'd400, 48'd0));
    send_item(fb(16'hFFFF, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
    send_item(fb(16'd3, 16'd7, 16'd400, 48'd0));
    wait_quiet();
  endtask

  task automatic test_registration();
    send_item(fb(REG_REQ_ID, 16'd1, 16'd400, 48'hA1B2_C3D4_E511));
    send_item(fb(REG_REQ_ID, 16'd5, 16'd400, 48'h0102_0304_0522));
    send_item(fb(REG_REQ_ID, 16'd8, 16'd400, 48'hFFFF_FFFF_FF11));
    // low byte zero matches every free slot
    send_item(fb(REG_REQ_ID, 16'd10, 16'd400, 48'h1234_5678_9A00));
    send_item(fb(REG_REQ_ID, 16'd11, 16'd400, 48'h0000_0000_0033));
    send_item(fb(REG_REQ_ID, 16'd12, 16'd400, 48'h0000_0000_0044));
    send_item(fb(REG_REQ_ID, 16'd2, 16'd400, 48'h0000_0000_0066));
    wait_quiet();
  endtask

  task automatic test_config_sweep();
    cfg_write(CFG_AP_MAC_0, 48'hFFFF_FFFF_FFFF);
    cfg_write(CFG_AP_MAC_1, 48'h0000_0000_0000);
    cfg_write(CFG_AP_MAC_2, 48'hAAAA_AAAA_AAAA);
    cfg_write(CFG_AP_MAC_3, 48'h5555_5555_5555);
    cfg_write(CFG_MAX_LED, 48'd15);
    cfg_write(CFG_POWER_THR, 48'd0);
    send_item(pkt(1, 11'd64, 16'h1234));
    send_item(fb(16'd2, 16'd15, 16'd0, 48'd0));
    send_item(fb(16'd2, 16'd13, 16'd0, 48'd0));
    send_item(fb(REG_REQ_ID, 16'd14, 16'd0, 48'h0000_0000_0022));
    wait_quiet();
    cfg_write(CFG_MAX_LED, 48'd1);
    cfg_write(CFG_POWER_THR, 48'hFFFF);
    send_item(pkt(1, 11'd100, 16'h4321));
    send_item(fb(16'd2, 16'd2, 16'hFFFF, 48'd0));
    send_item(fb(16'd2, 16'd1, 16'hFFFE, 48'd0));
    send_item(fb(16'd2, 16'd1, 16'hFFFF, 48'd0));
    wait_quiet();
    cfg_write(CFG_AP_MAC_0, AP_MAC_0_RST);
    cfg_write(CFG_AP_MAC_1, AP_MAC_1_RST);
    cfg_write(CFG_AP_MAC_2, AP_MAC_2_RST);
    cfg_write(CFG_AP_MAC_3, AP_MAC_3_RST);
    cfg_write(CFG_POWER_THR, 48'(POWER_THR_RST));
    cfg_write(CFG_MAX_LED, 48'(MAX_LED_RST));
  endtask

  task automatic test_backpressure();
    hold_req_cnt++;
    for (int i = 0; i < 20; i++) send_item(random_item());
    wait_quiet();
  endtask

  task automatic test_ring_drain();
    for (int i = 0; i < 16; i++) send_item(pkt(3, 11'($urandom()), 16'($urandom())));
    while (ring_count[3] > 0) send_item(fb(16'd4, 16'd1, 16'hFFFF, rand48()));
    send_item(fb(16'd4, 16'd1, 16'hFFFF, rand48()));
    wait_quiet();
  endtask

  task automatic run_random(int n, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) send_item(random_item());
    wait_quiet();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 10;
    recv_idle_pct = 76;
    test_packet_extremes();
    test_burst_drain();
    test_feedback_rejects();
    test_registration();
    test_config_sweep();
    test_backpressure();
    run_random(76, 10, 76);
    random_config();
    run_random(76, 76, 10);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_ring_drain();
    random_config();
    run_random(76, 0, 0);
    $display("Sent %0d transactions, checked %0d results, %0d register writes.",
             items_sent, results_seen, cfg_writes);
    $display("Covered enqueue, bursts, draining a ring to empty, registration, rejects, %s",
             "register sweeps and backpressure.");
    if (fails == 0 && pending_results.size() == 0) begin
      $display("feedback_driven_queue_dispatcher verification clean");
    end else begin
      $display("feedback_driven_queue_dispatcher verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/fdqd_pkg.sv
hdl/fdqd_desc_ram.sv
hdl/fdqd_seq.sv
hdl/feedback_driven_queue_dispatcher.sv
tb/sv/tb_feedback_driven_queue_dispatcher.sv
